// ----- rtl/cctt_pkg.sv -----
// types, codes and helpers of the cyclic can transmit table
// used by the top level; no dependencies
package cctt_pkg;

  localparam int FRAME_SLOTS_DEF   = 32;
  localparam int COUNTER_RULES_DEF = 32;
  localparam int DATA_BYTES        = 8;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_REMOVE  = 3'd1;
  localparam logic [2:0] CMD_CLEAR   = 3'd2;
  localparam logic [2:0] CMD_REPLACE = 3'd3;
  localparam logic [2:0] CMD_RULE    = 3'd4;
  localparam logic [2:0] CMD_TICK    = 3'd5;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  len;
    logic [3:0]  iface;
    logic [63:0] data;
  } slot_t;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  pos;
    logic [7:0]  value;
  } rule_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] id;
    logic [3:0]  len;
    logic [3:0]  iface;
    logic [63:0] data;
    logic [5:0]  count;
    logic        last;
  } res_t;

  function automatic res_t status_res(input logic [1:0] st);
    res_t r;
    r        = '0;
    r.kind   = KIND_STATUS;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic logic [63:0] put_byte(input logic [63:0] d, input logic [2:0] pos,
                                           input logic [7:0] v);
    logic [63:0] r;
    r = d;
    r[{pos, 3'b000} +: 8] = v;
    return r;
  endfunction

endpackage

// ----- rtl/cctt_ram.sv -----
// generic simple dual port ram with registered read
// no dependencies
module cctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/can_cyclic_transmit_table_core.sv -----
// cyclic can transmit table with rolling counters, top level
// depends on cctt_pkg and cctt_ram
//
// usage: one command transaction enters on the input channel (valid/ready);
// each command gives one status result, a cycle tick gives one frame result
// per used nonzero-id slot, then an end of cycle result carrying the count.
// last marks the final result of a command.
// sequence: clear and add rule go straight to their result; add, remove and
// replace search the used slots one per read; replace then walks the rules.
// a tick reads each used slot in turn, walks the rules for each slot with a
// nonzero id and sends its frame, then gives the end of cycle result. the
// pace is set by the single read port of the slot and rule memories, one
// entry per read.
// one command is worked at a time; ready is high only between commands.
// results go through an output register; a stalled receiver holds the
// sequencer at its next result, nothing is dropped.
// reset empties both tables by clearing the fill counts; the memories are
// not swept since only filled entries are ever read.
module can_cyclic_transmit_table_core
  import cctt_pkg::*;
#(
  parameter int FRAME_SLOTS   = FRAME_SLOTS_DEF,
  parameter int COUNTER_RULES = COUNTER_RULES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] can_id_i,
  input  logic [3:0]  frame_len_i,
  input  logic [3:0]  iface_i,
  input  logic [63:0] frame_data_i,
  input  logic [3:0]  byte_position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [31:0] out_id_o,
  output logic [3:0]  out_len_o,
  output logic [3:0]  out_iface_o,
  output logic [63:0] out_data_o,
  output logic [5:0]  sent_count_o,
  output logic        last_o
);

  localparam int SAW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int RAW = (COUNTER_RULES > 1) ? $clog2(COUNTER_RULES) : 1;
  localparam int SCW = $clog2(FRAME_SLOTS + 1);
  localparam int RCW = $clog2(COUNTER_RULES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_NF   = 4'd3;
  localparam logic [3:0] S_RRD  = 4'd4;
  localparam logic [3:0] S_RCMP = 4'd5;
  localparam logic [3:0] S_RDON = 4'd6;
  localparam logic [3:0] S_TRD  = 4'd7;
  localparam logic [3:0] S_TCHK = 4'd8;
  localparam logic [3:0] S_TNXT = 4'd9;
  localparam logic [3:0] S_EMIT = 4'd10;

  logic [3:0]     state_q, state_d, ret_q, ret_d;
  logic [2:0]     cmd_q, cmd_d;
  logic [31:0]    id_q, id_d;
  logic [3:0]     len_q, len_d, ifc_q, ifc_d;
  logic [63:0]    data_q, data_d;
  slot_t          slot_q, slot_d;
  logic [SCW-1:0] idx_q, idx_d, used_q, used_d, cnt_q, cnt_d;
  logic [RCW-1:0] ridx_q, ridx_d, rused_q, rused_d;
  res_t           res_q, res_d, out_q, out_d;
  logic           ovalid_q, ovalid_d;

  logic           s_we, r_we;
  logic [SAW-1:0] s_waddr;
  logic [RAW-1:0] r_waddr;
  slot_t          s_wdata, s_rdata;
  rule_t          r_wdata, r_rdata;
  logic [SCW-1:0] idx_inc;
  logic [RCW-1:0] ridx_inc;
  logic [7:0]     rv_inc;
  logic           out_free;

  cctt_ram #(.WIDTH($bits(slot_t)), .DEPTH(FRAME_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (idx_q[SAW-1:0]),
    .rdata_o (s_rdata)
  );

  cctt_ram #(.WIDTH($bits(rule_t)), .DEPTH(COUNTER_RULES)) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (ridx_q[RAW-1:0]),
    .rdata_o (r_rdata)
  );

  assign idx_inc    = idx_q + 1'b1;
  assign ridx_inc   = ridx_q + 1'b1;
  assign rv_inc     = r_rdata.value + 8'd1;
  assign out_free   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    cmd_d    = cmd_q;
    id_d     = id_q;
    len_d    = len_q;
    ifc_d    = ifc_q;
    data_d   = data_q;
    slot_d   = slot_q;
    idx_d    = idx_q;
    used_d   = used_q;
    cnt_d    = cnt_q;
    ridx_d   = ridx_q;
    rused_d  = rused_q;
    res_d    = res_q;
    out_d    = out_q;
    ovalid_d = ovalid_q && !out_ready_i;
    s_we     = 1'b0;
    s_waddr  = idx_q[SAW-1:0];
    s_wdata  = '0;
    r_we     = 1'b0;
    r_waddr  = ridx_q[RAW-1:0];
    r_wdata  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = command_i;
          id_d   = can_id_i;
          len_d  = frame_len_i;
          ifc_d  = iface_i;
          data_d = frame_data_i;
          idx_d  = '0;
          cnt_d  = '0;
          ret_d  = S_IDLE;
          case (command_i)
            CMD_ADD, CMD_REMOVE, CMD_REPLACE: begin
              state_d = (used_q == '0) ? S_NF : S_SRD;
            end
            CMD_CLEAR: begin
              used_d  = '0;
              res_d   = status_res(ST_OK);
              state_d = S_EMIT;
            end
            CMD_RULE: begin
              if (rused_q >= RCW'(COUNTER_RULES)) begin
                res_d = status_res(ST_FULL);
              end else begin
                r_we    = 1'b1;
                r_waddr = rused_q[RAW-1:0];
                r_wdata = '{id: can_id_i, pos: byte_position_i, value: 8'd0};
                rused_d = rused_q + 1'b1;
                res_d   = status_res(ST_OK);
              end
              state_d = S_EMIT;
            end
            CMD_TICK: begin
              if (used_q == '0) begin
                res_d       = '0;
                res_d.kind  = KIND_END;
                res_d.last  = 1'b1;
                state_d     = S_EMIT;
              end else begin
                state_d = S_TRD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SRD: state_d = S_SCMP;
      S_SCMP: begin
        if (s_rdata.id == id_q) begin
          case (cmd_q)
            CMD_ADD: begin
              res_d   = status_res(ST_DUP);
              state_d = S_EMIT;
            end
            CMD_REMOVE: begin
              s_we    = 1'b1;
              res_d   = status_res(ST_OK);
              state_d = S_EMIT;
            end
            default: begin
              slot_d  = s_rdata;
              ridx_d  = '0;
              state_d = (rused_q == '0) ? S_RDON : S_RRD;
            end
          endcase
        end else begin
          idx_d   = idx_inc;
          state_d = (idx_inc >= used_q) ? S_NF : S_SRD;
        end
      end
      S_NF: begin
        if (cmd_q == CMD_ADD) begin
          if (used_q >= SCW'(FRAME_SLOTS)) begin
            res_d = status_res(ST_FULL);
          end else begin
            s_we    = 1'b1;
            s_waddr = used_q[SAW-1:0];
            s_wdata = '{id: id_q, len: len_q, iface: ifc_q, data: data_q};
            used_d  = used_q + 1'b1;
            res_d   = status_res(ST_OK);
          end
        end else begin
          res_d = status_res(ST_NOTFOUND);
        end
        state_d = S_EMIT;
      end
      S_RRD: state_d = S_RCMP;
      S_RCMP: begin
        if (r_rdata.id == id_q && !r_rdata.pos[3]) begin
          if (cmd_q == CMD_TICK) begin
            r_we    = 1'b1;
            r_wdata = '{id: r_rdata.id, pos: r_rdata.pos, value: rv_inc};
            data_d  = put_byte(data_q, r_rdata.pos[2:0], rv_inc);
          end else begin
            data_d  = put_byte(data_q, r_rdata.pos[2:0], r_rdata.value);
          end
        end
        ridx_d  = ridx_inc;
        state_d = (ridx_inc >= rused_q) ? S_RDON : S_RRD;
      end
      S_RDON: begin
        if (cmd_q == CMD_REPLACE) begin
          s_we    = 1'b1;
          s_wdata = '{id: slot_q.id, len: slot_q.len, iface: slot_q.iface, data: data_q};
          res_d   = status_res(ST_OK);
          ret_d   = S_IDLE;
        end else begin
          res_d       = '0;
          res_d.kind  = KIND_FRAME;
          res_d.id    = slot_q.id;
          res_d.len   = slot_q.len;
          res_d.iface = slot_q.iface;
          res_d.data  = data_q;
          cnt_d       = cnt_q + 1'b1;
          ret_d       = S_TNXT;
        end
        state_d = S_EMIT;
      end
      S_TRD: state_d = S_TCHK;
      S_TCHK: begin
        slot_d = s_rdata;
        id_d   = s_rdata.id;
        data_d = s_rdata.data;
        ridx_d = '0;
        if (s_rdata.id == '0) begin
          state_d = S_TNXT;
        end else begin
          state_d = (rused_q == '0) ? S_RDON : S_RRD;
        end
      end
      S_TNXT: begin
        idx_d = idx_inc;
        if (idx_inc >= used_q) begin
          res_d       = '0;
          res_d.kind  = KIND_END;
          res_d.count = 6'(cnt_q);
          res_d.last  = 1'b1;
          ret_d       = S_IDLE;
          state_d     = S_EMIT;
        end else begin
          state_d = S_TRD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_d    = res_q;
          ovalid_d = 1'b1;
          state_d  = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      used_q   <= '0;
      rused_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      used_q   <= used_d;
      rused_q  <= rused_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    id_q   <= id_d;
    len_q  <= len_d;
    ifc_q  <= ifc_d;
    data_q <= data_d;
    slot_q <= slot_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    ridx_q <= ridx_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o  = ovalid_q;
  assign kind_o       = out_q.kind;
  assign status_o     = out_q.status;
  assign out_id_o     = out_q.id;
  assign out_len_o    = out_q.len;
  assign out_iface_o  = out_q.iface;
  assign out_data_o   = out_q.data;
  assign sent_count_o = out_q.count;
  assign last_o       = out_q.last;

endmodule
